// ===== rtl/buddy_block_allocator_assert.svh =====
// Assertion macros for the buddy block allocator.
// Used by the datapath. No other dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define BBA_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("buddy allocator check failed");
// Condition a implies condition b in the next cycle.
`define BBA_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("buddy allocator check failed");
`else
`define BBA_ASSERT_IMPLY(label, clk, rst, a, b)
`define BBA_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/bba_pkg.sv =====
// Shared constants, types and helper functions of the buddy block allocator.
// No dependencies.
package bba_pkg;

  localparam int MAX_ORDER    = 20;
  localparam int MIN_ORDER    = 5;
  localparam int HEADER_BYTES = 10;
  localparam int WORD_BYTES   = 4;
  localparam int ORDER_SPAN   = MAX_ORDER - MIN_ORDER;

  localparam int ORD_W   = 5;
  localparam int OFF_W   = 20;
  localparam int REQ_W   = 21;
  localparam int BYTES_W = 21;
  localparam int SIZ_W   = 22;
  localparam int TOT_W   = 23;
  localparam int STAT_W  = 2;

  localparam int SLOT_W     = ORDER_SPAN + 1;
  localparam int FW_BITS    = 32;
  localparam int FW_IDX_W   = 5;
  localparam int FW_AW      = SLOT_W - FW_IDX_W;
  localparam int FW_DEPTH   = 1 << FW_AW;
  localparam int UNIT_AW    = ORDER_SPAN;
  localparam int UNIT_DEPTH = 1 << UNIT_AW;
  localparam int NUM_ORD    = ORDER_SPAN + 1;
  localparam int KIDX_W     = 4;
  localparam int CNT_W      = ORDER_SPAN + 1;

  localparam logic [ORD_W-1:0] POOL_ORDER_RESET = 5'd20;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [ORD_W-1:0]     order;
    logic [BYTES_W-1:0]   payload;
  } alloc_entry_t;

  localparam int ENTRY_W = $bits(alloc_entry_t);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;
    logic seed;
    logic load_in;
    logic a_size;
    logic a_pick;
    logic scan_rd;
    logic scan_chk;
    logic split_rd;
    logic split_wr;
    logic a_commit;
    logic f_rd;
    logic f_chk;
    logic m_rd;
    logic m_chk;
    logic fin_rd;
    logic fin_wr;
    logic fail_nomem;
    logic fail_bad;
    logic out_load;
  } bba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic too_large;
    logic none_free;
    logic found;
    logic split_more;
    logic range_bad;
    logic entry_valid;
    logic merge_more;
    logic buddy_free;
    logic out_free;
  } bba_sts_t;

  // First free-map slot of order index k
  function automatic logic [SLOT_W-1:0] slot_base(logic [KIDX_W-1:0] k);
    return ~({SLOT_W{1'b1}} >> k);
  endfunction

  // Free-map slot of the block at offset off with order ord
  function automatic logic [SLOT_W-1:0] slot_of(logic [ORD_W-1:0] ord,
                                                logic [OFF_W-1:0] off);
    logic [KIDX_W-1:0] k;
    logic [OFF_W-1:0]  idx;
    k   = KIDX_W'(ord - ORD_W'(MIN_ORDER));
    idx = off >> ord;
    return slot_base(k) + idx[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/buddy_block_allocator.sv =====
// Buddy block allocator top level. An allocation sizes the request, picks the
// smallest order with a free block, scans the free map and splits down to the
// needed order; a free merges with each free buddy. One transaction is in work at
// a time; the next is taken in the cycle after the result loads, later while it stalls.
// Reset and every pool_order write run a clearing pass, then seed the top block.
// Depends on bba_pkg, bba_ctrl, bba_datapath and bba_ram.
module buddy_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bba_pkg::ORD_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [bba_pkg::REQ_W-1:0]   request_bytes,
  input  logic [bba_pkg::OFF_W-1:0]   free_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bba_pkg::STAT_W-1:0]  status,
  output logic [bba_pkg::OFF_W-1:0]   grant_offset,
  output logic [bba_pkg::ORD_W-1:0]   grant_order,
  output logic [bba_pkg::BYTES_W-1:0] used_bytes,
  output logic [bba_pkg::BYTES_W-1:0] peak_bytes,
  output logic [bba_pkg::BYTES_W-1:0] payload_bytes
);

  bba_pkg::bba_cmd_t cmd;
  bba_pkg::bba_sts_t sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .request_bytes (request_bytes),
    .free_offset   (free_offset),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .grant_offset  (grant_offset),
    .grant_order   (grant_order),
    .used_bytes    (used_bytes),
    .peak_bytes    (peak_bytes),
    .payload_bytes (payload_bytes)
  );

endmodule

// ===== rtl/bba_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bba_ctrl.sv =====
// Sequencing state machine of the buddy block allocator.
// Depends on bba_pkg for the command and status structs.
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  bba_pkg::bba_sts_t sts,
  output bba_pkg::bba_cmd_t cmd
);

  typedef enum logic [15:0] {
    S_CLEAR    = 16'b0000_0000_0000_0001,
    S_SEED     = 16'b0000_0000_0000_0010,
    S_IDLE     = 16'b0000_0000_0000_0100,
    S_A_SIZE   = 16'b0000_0000_0000_1000,
    S_A_PICK   = 16'b0000_0000_0001_0000,
    S_A_RD     = 16'b0000_0000_0010_0000,
    S_A_CHK    = 16'b0000_0000_0100_0000,
    S_SPLIT    = 16'b0000_0000_1000_0000,
    S_SPLIT_WR = 16'b0000_0001_0000_0000,
    S_F_RANGE  = 16'b0000_0010_0000_0000,
    S_F_CHK    = 16'b0000_0100_0000_0000,
    S_F_LOOP   = 16'b0000_1000_0000_0000,
    S_M_CHK    = 16'b0001_0000_0000_0000,
    S_FIN_RD   = 16'b0010_0000_0000_0000,
    S_FIN_WR   = 16'b0100_0000_0000_0000,
    S_OUT      = 16'b1000_0000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   in_fire;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_SEED;
      end
      S_SEED: begin
        cmd.seed   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          state_next  = (mode == bba_pkg::MODE_FREE) ? S_F_RANGE : S_A_SIZE;
        end
      end
      S_A_SIZE: begin
        cmd.a_size = 1'b1;
        state_next = S_A_PICK;
      end
      S_A_PICK: begin
        if (sts.too_large || sts.none_free) begin
          cmd.fail_nomem = 1'b1;
          state_next     = S_OUT;
        end else begin
          cmd.a_pick = 1'b1;
          state_next = S_A_RD;
        end
      end
      S_A_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_A_CHK;
      end
      S_A_CHK: begin
        cmd.scan_chk = 1'b1;
        state_next   = sts.found ? S_SPLIT : S_A_RD;
      end
      S_SPLIT: begin
        if (sts.split_more) begin
          cmd.split_rd = 1'b1;
          state_next   = S_SPLIT_WR;
        end else begin
          cmd.a_commit = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_SPLIT_WR: begin
        cmd.split_wr = 1'b1;
        state_next   = S_SPLIT;
      end
      S_F_RANGE: begin
        if (sts.range_bad) begin
          cmd.fail_bad = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.f_rd   = 1'b1;
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (sts.entry_valid) begin
          cmd.f_chk  = 1'b1;
          state_next = S_F_LOOP;
        end else begin
          cmd.fail_bad = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_F_LOOP: begin
        if (sts.merge_more) begin
          cmd.m_rd   = 1'b1;
          state_next = S_M_CHK;
        end else begin
          cmd.fin_rd = 1'b1;
          state_next = S_FIN_WR;
        end
      end
      S_M_CHK: begin
        cmd.m_chk  = 1'b1;
        state_next = sts.buddy_free ? S_F_LOOP : S_FIN_RD;
      end
      S_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_next = S_FIN_WR;
      end
      S_FIN_WR: begin
        cmd.fin_wr = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Advance state; a pool write restarts the clearing pass
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/bba_datapath.sv =====
// Datapath of the buddy block allocator: free map, allocation map, per-order
// free counts, byte counters and the result register. Uses bba_pkg and bba_ram.
module bba_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bba_pkg::ORD_W-1:0]           cfg_wdata,
  input  logic [bba_pkg::REQ_W-1:0]           request_bytes,
  input  logic [bba_pkg::OFF_W-1:0]           free_offset,
  input  bba_pkg::bba_cmd_t                   cmd,
  output bba_pkg::bba_sts_t                   sts,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [bba_pkg::STAT_W-1:0]          status,
  output logic [bba_pkg::OFF_W-1:0]           grant_offset,
  output logic [bba_pkg::ORD_W-1:0]           grant_order,
  output logic [bba_pkg::BYTES_W-1:0]         used_bytes,
  output logic [bba_pkg::BYTES_W-1:0]         peak_bytes,
  output logic [bba_pkg::BYTES_W-1:0]         payload_bytes
);

`include "buddy_block_allocator_assert.svh"

  // Free-map mask of the bits that belong to order index k within its word
  function automatic logic [bba_pkg::FW_BITS-1:0] region_mask(
      logic [bba_pkg::KIDX_W-1:0] k);
    logic [bba_pkg::SLOT_W-1:0]  base;
    logic [5:0]                  sz;
    logic [bba_pkg::FW_BITS-1:0] m;
    base = bba_pkg::slot_base(k);
    sz   = '0;
    if (k > bba_pkg::KIDX_W'(bba_pkg::ORDER_SPAN - bba_pkg::FW_IDX_W)) begin
      sz = 6'd1 << (bba_pkg::KIDX_W'(bba_pkg::ORDER_SPAN) - k);
      m  = ((bba_pkg::FW_BITS'(1) << sz) - bba_pkg::FW_BITS'(1)) << base[4:0];
    end else begin
      m = '1;
    end
    return m;
  endfunction

  // Registers
  logic [bba_pkg::ORD_W-1:0]   pool_order;
  logic [bba_pkg::UNIT_AW-1:0] clr_cnt;
  logic [bba_pkg::REQ_W-1:0]   req;
  logic [bba_pkg::OFF_W-1:0]   off;
  logic [bba_pkg::SIZ_W-1:0]   siz;
  logic [bba_pkg::ORD_W-1:0]   ord;
  logic [bba_pkg::ORD_W-1:0]   cur;
  logic                        too_large;
  logic [bba_pkg::FW_AW-1:0]   scan_addr;
  logic [bba_pkg::SLOT_W-1:0]  slot;
  logic [bba_pkg::CNT_W-1:0]   cnt [bba_pkg::NUM_ORD];
  logic [bba_pkg::BYTES_W-1:0] used_total;
  logic [bba_pkg::BYTES_W-1:0] peak_total;
  logic [bba_pkg::BYTES_W-1:0] payload_total;
  logic [bba_pkg::STAT_W-1:0]  res_status;
  logic [bba_pkg::OFF_W-1:0]   res_offset;
  logic [bba_pkg::ORD_W-1:0]   res_order;

  // RAM ports
  logic                         fr_we, fr_re;
  logic [bba_pkg::FW_AW-1:0]    fr_waddr, fr_raddr;
  logic [bba_pkg::FW_BITS-1:0]  fr_wdata, fr_rdata;
  logic                         al_we, al_re;
  logic [bba_pkg::UNIT_AW-1:0]  al_waddr, al_raddr;
  bba_pkg::alloc_entry_t        al_wentry, al_entry;
  logic [bba_pkg::ENTRY_W-1:0]  al_rdata;

  // Combinational helpers
  logic [bba_pkg::SIZ_W-1:0]   siz_c;
  logic [bba_pkg::TOT_W-1:0]   total_c;
  logic [bba_pkg::ORD_W-1:0]   ord_c;
  logic                        pick_any;
  logic [bba_pkg::KIDX_W-1:0]  pick_k;
  logic [bba_pkg::SLOT_W-1:0]  pick_base;
  logic [bba_pkg::KIDX_W-1:0]  cur_k, ord_k, pool_k;
  logic [bba_pkg::FW_BITS-1:0] scan_hits;
  logic [bba_pkg::FW_IDX_W-1:0] hit_idx;
  logic [bba_pkg::SLOT_W-1:0]  hit_rel;
  logic [bba_pkg::OFF_W-1:0]   hit_off;
  logic [bba_pkg::ORD_W-1:0]   split_ord;
  logic [bba_pkg::SLOT_W-1:0]  rd_slot;
  logic [bba_pkg::SLOT_W-1:0]  seed_slot;
  logic [bba_pkg::FW_BITS-1:0] slot_bit;
  logic [bba_pkg::BYTES_W-1:0] used_add;
  logic                        cnt_inc, cnt_dec;
  logic [bba_pkg::KIDX_W-1:0]  cnt_k;

  assign cur_k  = bba_pkg::KIDX_W'(cur - bba_pkg::ORD_W'(bba_pkg::MIN_ORDER));
  assign ord_k  = bba_pkg::KIDX_W'(ord - bba_pkg::ORD_W'(bba_pkg::MIN_ORDER));
  assign pool_k = bba_pkg::KIDX_W'(pool_order - bba_pkg::ORD_W'(bba_pkg::MIN_ORDER));

  // Size rounding and block order of the held request
  always_comb begin
    siz_c   = (bba_pkg::SIZ_W'(req) + bba_pkg::SIZ_W'(bba_pkg::WORD_BYTES - 1))
              & ~bba_pkg::SIZ_W'(bba_pkg::WORD_BYTES - 1);
    total_c = bba_pkg::TOT_W'(siz_c) + bba_pkg::TOT_W'(bba_pkg::HEADER_BYTES);
    ord_c   = bba_pkg::ORD_W'(bba_pkg::MAX_ORDER + 1);
    for (int o = bba_pkg::MAX_ORDER; o >= bba_pkg::MIN_ORDER; o--) begin
      if ((bba_pkg::TOT_W'(1) << o) >= total_c) ord_c = bba_pkg::ORD_W'(o);
    end
  end

  // Smallest order at or above the need that still has a free block
  always_comb begin
    pick_any = 1'b0;
    pick_k   = '0;
    for (int j = bba_pkg::NUM_ORD - 1; j >= 0; j--) begin
      if (cnt[j] != '0 && bba_pkg::KIDX_W'(j) >= ord_k &&
          bba_pkg::KIDX_W'(j) <= pool_k) begin
        pick_any = 1'b1;
        pick_k   = bba_pkg::KIDX_W'(j);
      end
    end
  end

  assign pick_base = bba_pkg::slot_base(pick_k);

  // Lowest free bit of the scanned word
  always_comb begin
    scan_hits = fr_rdata & region_mask(cur_k);
    hit_idx   = '0;
    for (int b = bba_pkg::FW_BITS - 1; b >= 0; b--) begin
      if (scan_hits[b]) hit_idx = bba_pkg::FW_IDX_W'(b);
    end
    hit_rel = {scan_addr, hit_idx} - bba_pkg::slot_base(cur_k);
    hit_off = bba_pkg::OFF_W'(hit_rel) << cur;
  end

  // Slot for the next free-map read
  always_comb begin
    split_ord = cur - bba_pkg::ORD_W'(1);
    if (cmd.split_rd) begin
      rd_slot = bba_pkg::slot_of(split_ord, off + (bba_pkg::OFF_W'(1) << split_ord));
    end else if (cmd.m_rd) begin
      rd_slot = bba_pkg::slot_of(ord, off ^ (bba_pkg::OFF_W'(1) << ord));
    end else begin
      rd_slot = bba_pkg::slot_of(ord, off);
    end
    seed_slot = bba_pkg::slot_of(pool_order, '0);
    slot_bit  = bba_pkg::FW_BITS'(1) << slot[bba_pkg::FW_IDX_W-1:0];
  end

  // Free-map port selection
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = slot[bba_pkg::SLOT_W-1:bba_pkg::FW_IDX_W];
    fr_wdata = fr_rdata | slot_bit;
    if (cmd.clr_step) begin
      fr_we    = 1'b1;
      fr_waddr = clr_cnt[bba_pkg::FW_AW-1:0];
      fr_wdata = '0;
    end else if (cmd.seed) begin
      fr_we    = 1'b1;
      fr_waddr = seed_slot[bba_pkg::SLOT_W-1:bba_pkg::FW_IDX_W];
      fr_wdata = bba_pkg::FW_BITS'(1) << seed_slot[bba_pkg::FW_IDX_W-1:0];
    end else if (cmd.scan_chk && sts.found) begin
      fr_we    = 1'b1;
      fr_waddr = scan_addr;
      fr_wdata = fr_rdata & ~(bba_pkg::FW_BITS'(1) << hit_idx);
    end else if (cmd.m_chk && sts.buddy_free) begin
      fr_we    = 1'b1;
      fr_wdata = fr_rdata & ~slot_bit;
    end else if (cmd.split_wr || cmd.fin_wr) begin
      fr_we    = 1'b1;
    end
    fr_re    = cmd.scan_rd || cmd.split_rd || cmd.m_rd || cmd.fin_rd;
    fr_raddr = cmd.scan_rd ? scan_addr : rd_slot[bba_pkg::SLOT_W-1:bba_pkg::FW_IDX_W];
  end

  // Allocation-map port selection
  always_comb begin
    al_we     = cmd.clr_step || cmd.a_commit || (cmd.f_chk && al_entry.valid);
    al_waddr  = cmd.clr_step ? clr_cnt : off[bba_pkg::OFF_W-1:bba_pkg::MIN_ORDER];
    al_wentry = '0;
    if (cmd.a_commit) begin
      al_wentry.valid   = 1'b1;
      al_wentry.order   = ord;
      al_wentry.payload = siz[bba_pkg::BYTES_W-1:0];
    end
    al_re    = cmd.f_rd;
    al_raddr = off[bba_pkg::OFF_W-1:bba_pkg::MIN_ORDER];
  end

  assign al_entry = bba_pkg::alloc_entry_t'(al_rdata);

  // Per-order free count update
  always_comb begin
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    cnt_k   = ord_k;
    if (cmd.scan_chk && sts.found) begin
      cnt_dec = 1'b1;
      cnt_k   = cur_k;
    end else if (cmd.split_wr) begin
      cnt_inc = 1'b1;
      cnt_k   = cur_k;
    end else if (cmd.m_chk && sts.buddy_free) begin
      cnt_dec = 1'b1;
    end else if (cmd.fin_wr) begin
      cnt_inc = 1'b1;
    end
  end

  assign used_add = used_total + (bba_pkg::BYTES_W'(1) << ord);

  // Status to the controller
  always_comb begin
    sts.clr_last    = &clr_cnt;
    sts.too_large   = too_large;
    sts.none_free   = !pick_any;
    sts.found       = |scan_hits;
    sts.split_more  = cur > ord;
    sts.range_bad   = ((off >> pool_order) != '0) ||
                      (off[bba_pkg::MIN_ORDER-1:0] != '0);
    sts.entry_valid = al_entry.valid;
    sts.merge_more  = ord < pool_order;
    sts.buddy_free  = |(fr_rdata & slot_bit);
    sts.out_free    = !out_valid || !out_stall;
  end

  // Pool order register and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_order <= bba_pkg::POOL_ORDER_RESET;
      clr_cnt    <= '0;
    end else if (cfg_we) begin
      if (cfg_wdata < bba_pkg::ORD_W'(bba_pkg::MIN_ORDER)) begin
        pool_order <= bba_pkg::ORD_W'(bba_pkg::MIN_ORDER);
      end else if (cfg_wdata > bba_pkg::ORD_W'(bba_pkg::MAX_ORDER)) begin
        pool_order <= bba_pkg::ORD_W'(bba_pkg::MAX_ORDER);
      end else begin
        pool_order <= cfg_wdata;
      end
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + bba_pkg::UNIT_AW'(1);
    end
  end

  // Free counts and byte counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_step) begin
      for (int j = 0; j < bba_pkg::NUM_ORD; j++) cnt[j] <= '0;
      used_total    <= '0;
      peak_total    <= '0;
      payload_total <= '0;
    end else begin
      for (int j = 0; j < bba_pkg::NUM_ORD; j++) begin
        if (cmd.seed && bba_pkg::KIDX_W'(j) == pool_k) begin
          cnt[j] <= bba_pkg::CNT_W'(1);
        end else if (cnt_inc && bba_pkg::KIDX_W'(j) == cnt_k) begin
          cnt[j] <= cnt[j] + bba_pkg::CNT_W'(1);
        end else if (cnt_dec && bba_pkg::KIDX_W'(j) == cnt_k) begin
          cnt[j] <= cnt[j] - bba_pkg::CNT_W'(1);
        end
      end
      if (cmd.a_commit) begin
        used_total    <= used_add;
        payload_total <= payload_total + siz[bba_pkg::BYTES_W-1:0];
        if (used_add > peak_total) peak_total <= used_add;
      end else if (cmd.f_chk && al_entry.valid) begin
        used_total    <= used_total - (bba_pkg::BYTES_W'(1) << al_entry.order);
        payload_total <= payload_total - al_entry.payload;
      end
    end
  end

  // Transaction working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req        <= request_bytes;
      off        <= free_offset;
      res_status <= bba_pkg::ST_OK;
      res_offset <= '0;
      res_order  <= '0;
    end
    if (cmd.a_size) begin
      siz       <= siz_c;
      ord       <= ord_c;
      too_large <= ord_c > pool_order;
    end
    if (cmd.a_pick) begin
      cur       <= bba_pkg::ORD_W'(pick_k) + bba_pkg::ORD_W'(bba_pkg::MIN_ORDER);
      scan_addr <= pick_base[bba_pkg::SLOT_W-1:bba_pkg::FW_IDX_W];
    end
    if (cmd.scan_chk) begin
      if (sts.found) begin
        off <= hit_off;
      end else begin
        scan_addr <= scan_addr + bba_pkg::FW_AW'(1);
      end
    end
    if (cmd.split_rd) begin
      cur <= split_ord;
    end
    if (cmd.split_rd || cmd.m_rd || cmd.fin_rd) begin
      slot <= rd_slot;
    end
    if (cmd.a_commit) begin
      res_status <= bba_pkg::ST_OK;
      res_offset <= off;
      res_order  <= ord;
    end
    if (cmd.f_chk && al_entry.valid) begin
      ord       <= al_entry.order;
      res_order <= al_entry.order;
    end
    if (cmd.m_chk && sts.buddy_free) begin
      off <= off & ~(bba_pkg::OFF_W'(1) << ord);
      ord <= ord + bba_pkg::ORD_W'(1);
    end
    if (cmd.fail_nomem) begin
      res_status <= bba_pkg::ST_NOMEM;
      res_offset <= '0;
      res_order  <= '0;
    end
    if (cmd.fail_bad) begin
      res_status <= bba_pkg::ST_BAD_FREE;
      res_offset <= '0;
      res_order  <= '0;
    end
  end

  // Output register: load a finished transaction, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status        <= res_status;
      grant_offset  <= res_offset;
      grant_order   <= res_order;
      used_bytes    <= used_total;
      peak_bytes    <= peak_total;
      payload_bytes <= payload_total;
    end
  end

  bba_ram #(
    .WIDTH (bba_pkg::FW_BITS),
    .DEPTH (bba_pkg::FW_DEPTH)
  ) u_free_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .re    (fr_re),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  bba_ram #(
    .WIDTH (bba_pkg::ENTRY_W),
    .DEPTH (bba_pkg::UNIT_DEPTH)
  ) u_alloc_ram (
    .clk   (clk),
    .we    (al_we),
    .waddr (al_waddr),
    .wdata (al_wentry),
    .re    (al_re),
    .raddr (al_raddr),
    .rdata (al_rdata)
  );

  // Payload bytes never exceed the block bytes that hold them
  `BBA_ASSERT_IMPLY(a_payload_le_used, clk, rst, 1'b1, payload_total <= used_total)
  // Peak tracks the used total
  `BBA_ASSERT_IMPLY(a_peak_ge_used, clk, rst, 1'b1, peak_total >= used_total)
  // A granted block is aligned and inside the pool
  `BBA_ASSERT_IMPLY(a_grant_ok, clk, rst, cmd.a_commit,
                    ord <= pool_order && off[bba_pkg::MIN_ORDER-1:0] == '0)
  // A split never goes below the requested order
  `BBA_ASSERT_NEXT(a_split_floor, clk, rst, cmd.split_rd, cur >= ord)

endmodule

// ===== test/testbench.sv =====
// Testbench for buddy_block_allocator: directed and random allocate/free traffic
// checked against a behavioral buddy predictor. Depends on bba_pkg and the RTL.
module testbench;

  typedef struct {
    logic [bba_pkg::STAT_W-1:0]  status;
    logic [bba_pkg::OFF_W-1:0]   offset;
    logic [bba_pkg::ORD_W-1:0]   order;
    logic [bba_pkg::BYTES_W-1:0] used;
    logic [bba_pkg::BYTES_W-1:0] peak;
    logic [bba_pkg::BYTES_W-1:0] payload;
  } grant_t;

  localparam int WATCHDOG_LIMIT = 120000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [bba_pkg::ORD_W-1:0]    cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         mode = bba_pkg::MODE_ALLOC;
  logic [bba_pkg::REQ_W-1:0]    request_bytes = '0;
  logic [bba_pkg::OFF_W-1:0]    free_offset = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [bba_pkg::STAT_W-1:0]   status;
  logic [bba_pkg::OFF_W-1:0]    grant_offset;
  logic [bba_pkg::ORD_W-1:0]    grant_order;
  logic [bba_pkg::BYTES_W-1:0]  used_bytes;
  logic [bba_pkg::BYTES_W-1:0]  peak_bytes;
  logic [bba_pkg::BYTES_W-1:0]  payload_bytes;

  // Predictor state
  bit          fmap [65536];
  bit          blk_valid [32768];
  int unsigned blk_order [32768];
  int unsigned blk_payload [32768];
  int unsigned pool_ord;
  int unsigned used_sum, peak_sum, payload_sum;

  grant_t      expected_grants[$];
  int unsigned live_blocks[$];
  bit          failed = 1'b0;
  bit          send_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  int          hold_req = 0;

  buddy_block_allocator uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .request_bytes(request_bytes), .free_offset(free_offset),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .grant_offset(grant_offset), .grant_order(grant_order),
    .used_bytes(used_bytes), .peak_bytes(peak_bytes), .payload_bytes(payload_bytes)
  );

  always #10 clk = ~clk;

  function automatic int unsigned slot_idx(int unsigned ord, int unsigned off);
    int unsigned k;
    k = ord - bba_pkg::MIN_ORDER;
    return ((32'd1 << 16) - (32'd1 << (16 - k)) + (off >> ord)) & 32'hFFFF;
  endfunction

  // Clear maps and counters and seed the top block
  function automatic void pool_init(int unsigned v);
    pool_ord = (v < bba_pkg::MIN_ORDER) ? bba_pkg::MIN_ORDER :
               (v > bba_pkg::MAX_ORDER) ? bba_pkg::MAX_ORDER : v;
    foreach (fmap[i]) fmap[i] = 1'b0;
    foreach (blk_valid[i]) begin
      blk_valid[i] = 1'b0;
      blk_order[i] = 0;
      blk_payload[i] = 0;
    end
    fmap[slot_idx(pool_ord, 0)] = 1'b1;
    used_sum = 0;
    peak_sum = 0;
    payload_sum = 0;
    live_blocks.delete();
  endfunction

  // Expected outcome of one transaction; updates the predictor state
  function automatic grant_t predict_grant(logic m, logic [bba_pkg::REQ_W-1:0] req,
                                           logic [bba_pkg::OFF_W-1:0] off_in);
    grant_t g;
    int unsigned siz, total, ord, cur, n, off, boff, s, idx;
    bit found;
    g.status = bba_pkg::ST_OK;
    g.offset = '0;
    g.order = '0;
    found = 1'b0;
    off = 0;
    if (m == bba_pkg::MODE_ALLOC) begin
      siz = ((req + bba_pkg::WORD_BYTES - 1) / bba_pkg::WORD_BYTES) * bba_pkg::WORD_BYTES;
      total = siz + bba_pkg::HEADER_BYTES;
      ord = bba_pkg::MIN_ORDER;
      while (ord <= pool_ord && (32'd1 << ord) < total) ord++;
      if (ord > pool_ord) begin
        g.status = bba_pkg::ST_NOMEM;
      end else begin
        cur = ord;
        while (cur <= pool_ord && !found) begin
          n = 32'd1 << (pool_ord - cur);
          for (int unsigned i = 0; i < n; i++) begin
            if (fmap[slot_idx(cur, i << cur)]) begin
              off = i << cur;
              found = 1'b1;
              break;
            end
          end
          cur++;
        end
        if (!found) begin
          g.status = bba_pkg::ST_NOMEM;
        end else begin
          cur--;
          fmap[slot_idx(cur, off)] = 1'b0;
          while (cur > ord) begin
            cur--;
            fmap[slot_idx(cur, off + (32'd1 << cur))] = 1'b1;
          end
          idx = off >> bba_pkg::MIN_ORDER;
          blk_valid[idx] = 1'b1;
          blk_order[idx] = ord;
          blk_payload[idx] = siz;
          used_sum += 32'd1 << ord;
          payload_sum += siz;
          if (used_sum > peak_sum) peak_sum = used_sum;
          g.offset = off[bba_pkg::OFF_W-1:0];
          g.order = ord[bba_pkg::ORD_W-1:0];
          live_blocks.push_back(off);
        end
      end
    end else begin
      off = off_in;
      idx = off >> bba_pkg::MIN_ORDER;
      if (off >= (32'd1 << pool_ord) || off[bba_pkg::MIN_ORDER-1:0] != 0 ||
          !blk_valid[idx]) begin
        g.status = bba_pkg::ST_BAD_FREE;
      end else begin
        ord = blk_order[idx];
        g.order = ord[bba_pkg::ORD_W-1:0];
        used_sum -= 32'd1 << ord;
        payload_sum -= blk_payload[idx];
        blk_valid[idx] = 1'b0;
        blk_order[idx] = 0;
        blk_payload[idx] = 0;
        foreach (live_blocks[i]) begin
          if (live_blocks[i] == off) begin
            live_blocks.delete(i);
            break;
          end
        end
        // Merge upward while the buddy is free
        while (ord < pool_ord) begin
          boff = off ^ (32'd1 << ord);
          s = slot_idx(ord, boff);
          if (!fmap[s]) break;
          fmap[s] = 1'b0;
          if (boff < off) off = boff;
          ord++;
        end
        fmap[slot_idx(ord, off)] = 1'b1;
      end
    end
    g.used = used_sum[bba_pkg::BYTES_W-1:0];
    g.peak = peak_sum[bba_pkg::BYTES_W-1:0];
    g.payload = payload_sum[bba_pkg::BYTES_W-1:0];
    return g;
  endfunction

  // Send one transaction and record its expected grant
  task automatic send_item(logic m, logic [bba_pkg::REQ_W-1:0] req,
                           logic [bba_pkg::OFF_W-1:0] off);
    int gap;
    int r;
    mode <= m;
    request_bytes <= req;
    free_offset <= off;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_grants.push_back(predict_grant(m, req, off));
    r = $urandom_range(0, 99);
    gap = !send_gaps ? 0 : (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                   : $urandom_range(20, 80);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_grants();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write pool_order once the allocator is idle
  task automatic write_pool_order(logic [bba_pkg::ORD_W-1:0] v);
    drain_grants();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_init(v);
  endtask

  task automatic alloc_req(int unsigned req);
    send_item(bba_pkg::MODE_ALLOC, req[bba_pkg::REQ_W-1:0], '0);
  endtask

  task automatic free_req(int unsigned off);
    send_item(bba_pkg::MODE_FREE, '0, off[bba_pkg::OFF_W-1:0]);
  endtask

  // Edge sizes, bad frees, merges and pool reconfiguration
  task automatic test_directed();
    alloc_req(0);
    alloc_req(22);
    alloc_req(1048576);
    alloc_req(21'h1FFFFF);
    alloc_req(1048566);
    alloc_req(1048564);
    free_req(3);
    free_req(20'hFFFFF);
    free_req(64);
    free_req(0);
    free_req(0);
    write_pool_order(5'd5);
    alloc_req(0);
    alloc_req(0);
    free_req(32);
    free_req(0);
    alloc_req(22);
    write_pool_order(5'd31);
    alloc_req(1048564);
    alloc_req(1);
    free_req(0);
    write_pool_order(5'd0);
    alloc_req(22);
    alloc_req(1);
    free_req(0);
  endtask

  // Random mix: mostly frees of live blocks and allocs, some noise
  task automatic random_item();
    int r;
    int unsigned req;
    r = $urandom_range(0, 99);
    if (r < 42 && live_blocks.size() != 0) begin
      free_req(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
    end else if (r < 50) begin
      if ($urandom_range(0, 1)) free_req($urandom & 32'hFFFFF);
      else free_req(($urandom_range(0, (1 << pool_ord) - 1)) & ~32'h1F);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) req = $urandom_range(0, 64);
      else if (r < 85) req = $urandom_range(0, 1 << (pool_ord - 2));
      else if (r < 95) req = $urandom_range(0, 1 << pool_ord);
      else req = $urandom & 32'h1FFFFF;
      alloc_req(req);
    end
  endtask

  task automatic test_random(logic [bba_pkg::ORD_W-1:0] pool, int count);
    write_pool_order(pool);
    repeat (count) random_item();
  endtask

  // Stall the sink for a long stretch while items keep coming, then run source and sink without gaps
  task automatic test_backpressure();
    hold_req = 400;
    repeat (6) random_item();
    drain_grants();
    send_gaps = 1'b0;
    sink_gaps = 1'b0;
    repeat (60) random_item();
    send_gaps = 1'b1;
    sink_gaps = 1'b1;
    drain_grants();
    repeat (40) random_item();
  endtask

  // Sink stall: mostly ready, some short and a few long stalls
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!sink_gaps) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: out_stall <= 1'b0;
        [70:97]: out_stall <= 1'b1;
        default: begin
          out_stall <= 1'b1;
          hold_left = $urandom_range(10, 40);
        end
      endcase
    end
  end

  // Check each accepted grant against the oldest expectation
  always @(posedge clk) begin
    grant_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected grant: status %0d offset %0d", status, grant_offset);
        failed = 1'b1;
      end else begin
        e = expected_grants.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          failed = 1'b1;
        end
        if (grant_offset !== e.offset) begin
          $error("grant_offset: expected %0d, got %0d", e.offset, grant_offset);
          failed = 1'b1;
        end
        if (grant_order !== e.order) begin
          $error("grant_order: expected %0d, got %0d", e.order, grant_order);
          failed = 1'b1;
        end
        if (used_bytes !== e.used) begin
          $error("used_bytes: expected %0d, got %0d", e.used, used_bytes);
          failed = 1'b1;
        end
        if (peak_bytes !== e.peak) begin
          $error("peak_bytes: expected %0d, got %0d", e.peak, peak_bytes);
          failed = 1'b1;
        end
        if (payload_bytes !== e.payload) begin
          $error("payload_bytes: expected %0d, got %0d", e.payload, payload_bytes);
          failed = 1'b1;
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    pool_init(bba_pkg::POOL_ORDER_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(5'd9, 300);
    test_random(5'd12, 300);
    test_backpressure();
    test_random(5'd20, 250);
    test_random(5'($urandom_range(0, 31)), 200);
    drain_grants();
    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== buddy_block_allocator.f =====
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_datapath.sv
rtl/buddy_block_allocator.sv
test/testbench.sv
